FILE: sv/kdf_pkg.sv
// Shared types and codes for the keyed dedup FIFO.
package kdf_pkg;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_ERASE  = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_ERASED   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_BATCH    = 3'd5;
  localparam logic [2:0] ST_EMPTY    = 3'd6;

  localparam logic REG_MAX_ENTRIES = 1'b0;
  localparam logic REG_BATCH_LIMIT = 1'b1;

  // Command handed from the front end to the back end.
  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] root_key;
    logic [63:0] permit_hash;
    logic        permit_final;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] out_root;
    logic [63:0] out_hash;
    logic        out_final;
    logic        last;
    logic [6:0]  occupancy;
  } res_t;

endpackage

FILE: sv/kdf_front.sv
// Front end: accepts input beats, drops unused ops, queues commands.
module kdf_front #(
  parameter int QDEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  kdf_pkg::cmd_t in_cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output kdf_pkg::cmd_t cmd
);
  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  kdf_pkg::cmd_t q [QDEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          push, pop, legal;

  assign legal     = (in_cmd.op != kdf_pkg::OP_UNUSED);
  assign in_ready  = (count != (AW+1)'(QDEPTH));
  assign push      = in_valid && in_ready && legal;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= in_cmd;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(QDEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(QDEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

FILE: sv/kdf_back.sv
// Back end: slot memory, arrival-order list and the scan sequencer.
module kdf_back #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [6:0]    max_entries,
  input  logic [6:0]    batch_limit,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  kdf_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output kdf_pkg::res_t res
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRCH  = 4'd1;
  localparam logic [3:0] S_SRCHD = 4'd2;
  localparam logic [3:0] S_SHIFT = 4'd3;
  localparam logic [3:0] S_SHRD  = 4'd4;
  localparam logic [3:0] S_FREE  = 4'd5;
  localparam logic [3:0] S_APP   = 4'd6;
  localparam logic [3:0] S_POPRD = 4'd7;
  localparam logic [3:0] S_POPD  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_POPNX = 4'd10;
  localparam logic [3:0] S_SHWR  = 4'd11;

  // Slot store: key, hash and final flag in one memory row.
  logic [128:0]  slot_mem [DEPTH];
  logic [AW-1:0] order_mem [DEPTH];
  logic [DEPTH-1:0] slot_valid;

  logic [3:0]    state;
  kdf_pkg::cmd_t c;
  logic [CW-1:0] fill_count;
  logic [CW-1:0] idx;          // position in order list
  logic [AW-1:0] cur_slot;
  logic [128:0]  row;
  logic [AW-1:0] ord_rd;
  logic [AW-1:0] mem_addr;
  logic [6:0]    remain;       // pop entries still to emit
  logic          after_push;   // append follows removal
  logic [2:0]    pend_status;
  logic [AW-1:0] free_slot;
  logic          have_free;

  // Lowest free slot
  always_comb begin
    free_slot = '0;
    have_free = 1'b0;
    for (int i = DEPTH-1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_slot = AW'(i);
        have_free = 1'b1;
      end
    end
  end

  logic [CW-1:0] limit;
  assign limit = (int'(max_entries) > DEPTH) ? CW'(DEPTH) : CW'(max_entries);

  assign cmd_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    ord_rd <= order_mem[idx[AW-1:0]];
    row    <= slot_mem[mem_addr];
  end

  assign mem_addr = ord_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      slot_valid <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (state == S_OUT && (!res_valid || res_ready)) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            c   <= cmd;
            idx <= '0;
            if (cmd.op == kdf_pkg::OP_POP) begin
              if (fill_count == '0) begin
                pend_status <= kdf_pkg::ST_EMPTY;
                state       <= S_OUT;
                remain      <= 7'd0;
              end else begin
                remain <= ((batch_limit == 7'd0) ? 7'd1 :
                           (batch_limit > 7'd64) ? 7'd64 : batch_limit);
                state  <= S_POPRD;
              end
            end else begin
              state <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          // order entry idx is being read
          if (idx == fill_count) begin
            if (c.op == kdf_pkg::OP_ERASE) begin
              pend_status <= kdf_pkg::ST_NOTFOUND;
              state       <= S_OUT;
            end else if (fill_count >= limit) begin
              pend_status <= kdf_pkg::ST_FULL;
              state       <= S_OUT;
            end else begin
              after_push <= 1'b0;
              state      <= S_APP;
            end
          end else begin
            state <= S_SRCHD;
          end
        end
        S_SRCHD: begin
          // row of slot ord_rd arrives next cycle; wait once
          cur_slot <= ord_rd;
          state    <= S_FREE;
        end
        S_FREE: begin
          if (slot_valid[cur_slot] && row[128:65] == c.root_key) begin
            if (c.op == kdf_pkg::OP_PUSH && row[64:1] == c.permit_hash) begin
              pend_status <= kdf_pkg::ST_DUP;
              state       <= S_OUT;
            end else begin
              slot_valid[cur_slot] <= 1'b0;
              after_push <= (c.op == kdf_pkg::OP_PUSH);
              state      <= S_SHIFT;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SRCH;
          end
        end
        S_SHIFT: begin
          // close the gap at idx, one entry per pass through S_SHRD and S_SHWR
          if (idx + 1'b1 >= fill_count) begin
            fill_count <= fill_count - 1'b1;
            if (after_push) state <= S_APP;
            else begin
              pend_status <= (c.op == kdf_pkg::OP_POP) ? kdf_pkg::ST_BATCH
                                                       : kdf_pkg::ST_ERASED;
              state <= (c.op == kdf_pkg::OP_POP) ? S_POPNX : S_OUT;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SHRD;
          end
        end
        S_SHRD: begin
          // order entry idx lands in ord_rd next cycle
          state <= S_SHWR;
        end
        S_SHWR: begin
          order_mem[idx[AW-1:0] - 1'b1] <= ord_rd;
          state <= S_SHIFT;
        end
        S_APP: begin
          if (have_free) begin
            slot_mem[free_slot]   <= {c.root_key, c.permit_hash, c.permit_final};
            slot_valid[free_slot] <= 1'b1;
            order_mem[fill_count[AW-1:0]] <= free_slot;
            fill_count <= fill_count + 1'b1;
          end
          pend_status <= kdf_pkg::ST_ADDED;
          state       <= S_OUT;
        end
        S_POPRD: begin
          idx   <= '0;
          state <= S_POPD;
        end
        S_POPD: begin
          // ord_rd holds head slot; row follows
          cur_slot <= ord_rd;
          state    <= S_OUT;
          pend_status <= kdf_pkg::ST_BATCH;
          remain   <= remain;
          c.op     <= kdf_pkg::OP_POP;
          idx      <= '0;
          after_push <= 1'b1;
        end
        S_OUT: begin
          if (!res_valid || res_ready) begin
            res.status <= pend_status;
            if (pend_status == kdf_pkg::ST_BATCH && after_push) begin
              // pop: emit head, then remove it
              res.out_root  <= row[128:65];
              res.out_hash  <= row[64:1];
              res.out_final <= row[0];
              res.last      <= (remain == 7'd1) || (fill_count == CW'(1));
              res.occupancy <= 7'(fill_count - 1'b1);
              slot_valid[cur_slot] <= 1'b0;
              remain     <= remain - 1'b1;
              after_push <= 1'b0;
              idx        <= '0;
              state      <= S_SHIFT;
            end else begin
              res.out_root  <= '0;
              res.out_hash  <= '0;
              res.out_final <= 1'b0;
              res.last      <= 1'b1;
              res.occupancy <= 7'(fill_count);
              state         <= S_IDLE;
            end
          end
        end
        S_POPNX: begin
          if (remain == 7'd0 || fill_count == '0) state <= S_IDLE;
          else begin
            idx   <= '0;
            state <= S_POPRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/keyed_dedup_fifo_top.sv
// Top level of the keyed dedup FIFO: config registers, front and back end.
// Push/erase: a key scan in arrival order, plus an order-list shift when an entry
// is removed; pop: an order-list shift after each emitted entry.
// One command is worked on at a time in the back end; a 2-entry command queue
// decouples input. Reset (synchronous, rst high) empties the queue and sets
// both limits to 64; slot contents stay undefined until written.
module keyed_dedup_fifo_top #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [6:0]    cfg_data,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [135:0]  s_tdata,   // op, root_key, permit_hash, permit_final
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [143:0]  m_tdata,   // status, out_root, out_hash, out_final, occupancy
  output logic          m_tlast
);
  logic [6:0] max_entries, batch_limit;
  kdf_pkg::cmd_t in_cmd, cmd;
  kdf_pkg::res_t res;
  logic cmd_valid, cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= 7'd64;
      batch_limit <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == kdf_pkg::REG_MAX_ENTRIES) max_entries <= cfg_data;
      else                                      batch_limit <= cfg_data;
    end
  end

  assign in_cmd.op           = s_tdata[1:0];
  assign in_cmd.root_key     = s_tdata[65:2];
  assign in_cmd.permit_hash  = s_tdata[129:66];
  assign in_cmd.permit_final = s_tdata[130];

  kdf_front #(.QDEPTH(2)) u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd,
    .cmd_valid, .cmd_ready, .cmd
  );

  kdf_back #(.DEPTH(DEPTH)) u_back (
    .clk, .rst, .max_entries, .batch_limit, .cmd_valid, .cmd_ready, .cmd,
    .res_valid(m_tvalid), .res_ready(m_tready), .res
  );

  assign m_tdata = {5'd0, res.occupancy, res.out_final, res.out_hash,
                    res.out_root, res.status};
  assign m_tlast = res.last;
endmodule
